// ===== design/lds_pkg.sv =====
package lds_pkg;

    localparam int MAX_STEPS = 48;
    localparam int STK_AW    = 6;
    localparam int OPW       = 32;
    localparam int WW        = 64;

    typedef enum logic [1:0] {
        MS_BS = 2'd0,
        MS_SX = 2'd1,
        MS_SY = 2'd2
    } lds_msel_t;

    typedef struct packed {
        logic      load;
        logic      div_start;
        logic      div_c;
        logic      push;
        logic      bs_read;
        logic      mul_start;
        lds_msel_t mul_sel;
        logic      bs_update;
        logic      sx_store;
        logic      sy_store;
        logic      set_nosol;
        logic      out_load;
    } lds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic q_zero;
        logic n_full;
        logic n_zero;
        logic g_zero;
        logic rem_nz;
    } lds_sts_t;

endpackage

// ===== design/lds_ctrl.sv =====
module lds_ctrl
    import lds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  lds_sts_t sts,
    output lds_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_CHECK   = 11'b00000000010,
        S_DIV     = 11'b00000000100,
        S_BS_RD   = 11'b00000001000,
        S_BS_MUL  = 11'b00000010000,
        S_BS_WAIT = 11'b00000100000,
        S_CDIV    = 11'b00001000000,
        S_CDIV_W  = 11'b00010000000,
        S_MX      = 11'b00100000000,
        S_MY      = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MS_BS;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.q_zero || sts.n_full)
                begin
                    state_next = S_BS_RD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_BS_RD:
            begin
                if (sts.n_zero)
                begin
                    state_next = S_CDIV;
                end
                else
                begin
                    cmd.bs_read = 1'b1;
                    state_next  = S_BS_MUL;
                end
            end
            S_BS_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_BS;
                state_next    = S_BS_WAIT;
            end
            S_BS_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.bs_update = 1'b1;
                    state_next    = S_BS_RD;
                end
            end
            S_CDIV:
            begin
                if (sts.g_zero)
                begin
                    cmd.set_nosol = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_c     = 1'b1;
                    state_next    = S_CDIV_W;
                end
            end
            S_CDIV_W:
            begin
                if (sts.div_done)
                begin
                    if (sts.rem_nz)
                    begin
                        cmd.set_nosol = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MS_SX;
                        state_next    = S_MX;
                    end
                end
            end
            S_MX:
            begin
                if (sts.mul_done)
                begin
                    cmd.sx_store  = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MS_SY;
                    state_next    = S_MY;
                end
            end
            S_MY:
            begin
                if (sts.mul_done)
                begin
                    cmd.sy_store = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/lds_dp.sv =====
module lds_dp
    import lds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lds_cmd_t              cmd,
    output lds_sts_t              sts,
    input  logic signed [OPW-1:0] coef_a,
    input  logic signed [OPW-1:0] coef_b,
    input  logic signed [OPW-1:0] rhs_c,
    output logic signed [WW-1:0]  sol_x,
    output logic signed [WW-1:0]  sol_y,
    output logic signed [OPW-1:0] gcd_value,
    output logic                  no_solution
);

    // Equation state.
    logic signed [OPW-1:0] p_reg, q_reg, c_reg;
    logic                  swap_reg;
    logic [STK_AW-1:0]     n_reg;
    logic [WW-1:0]         x1_reg, y1_reg;
    logic [WW-1:0]         solx_reg, soly_reg;
    logic                  nosol_reg;
    logic [OPW-1:0]        stack_mem [MAX_STEPS];
    logic [OPW-1:0]        rd_data_reg;

    // Output registers.
    logic [WW-1:0]         ox_reg, oy_reg;
    logic [OPW-1:0]        og_reg;
    logic                  onos_reg;

    // Restoring divider on magnitudes.
    logic [OPW-1:0]        dv_rem_reg, dv_quo_reg, dv_den_reg;
    logic [4:0]            dv_cnt_reg;
    logic                  dv_busy_reg, dv_done_reg, dv_negq_reg, dv_negr_reg;
    logic signed [OPW-1:0] dv_num, dv_dsr;
    logic [OPW:0]          dv_sh, dv_diff;
    logic [OPW-1:0]        quo_s, rem_s;
    logic [OPW:0]          k33;

    // Three-partial 64-bit product, low half only.
    logic [WW-1:0]         ma_reg, mb_reg, mp_reg, acc_reg;
    logic [1:0]            mc_cnt_reg;
    logic                  mc_busy_reg, mc_done_reg;
    logic [WW-1:0]         ma_sel, mb_sel, bx, by;
    logic [OPW-1:0]        pa, pb;

    function automatic logic [OPW-1:0] mag(input logic [OPW-1:0] v);
        mag = v[OPW-1] ? (~v + 1'b1) : v;
    endfunction

    assign dv_num  = cmd.div_c ? c_reg : p_reg;
    assign dv_dsr  = cmd.div_c ? p_reg : q_reg;
    assign dv_sh   = {dv_rem_reg, dv_quo_reg[OPW-1]};
    assign dv_diff = dv_sh - {1'b0, dv_den_reg};
    assign quo_s   = dv_negq_reg ? (~dv_quo_reg + 1'b1) : dv_quo_reg;
    assign rem_s   = dv_negr_reg ? (~dv_rem_reg + 1'b1) : dv_rem_reg;
    assign k33     = dv_negq_reg ? (~{1'b0, dv_quo_reg} + 1'b1) : {1'b0, dv_quo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else
        begin
            dv_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= '0;
            end
            else if (dv_busy_reg)
            begin
                dv_cnt_reg <= dv_cnt_reg + 1'b1;
                if (dv_cnt_reg == 5'(OPW - 1))
                begin
                    dv_busy_reg <= 1'b0;
                    dv_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dv_rem_reg  <= '0;
            dv_quo_reg  <= mag(dv_num);
            dv_den_reg  <= mag(dv_dsr);
            dv_negq_reg <= dv_num[OPW-1] ^ dv_dsr[OPW-1];
            dv_negr_reg <= dv_num[OPW-1];
        end
        else if (dv_busy_reg)
        begin
            if (!dv_diff[OPW])
            begin
                dv_rem_reg <= dv_diff[OPW-1:0];
                dv_quo_reg <= {dv_quo_reg[OPW-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_sh[OPW-1:0];
                dv_quo_reg <= {dv_quo_reg[OPW-2:0], 1'b0};
            end
        end
    end

    // The Bezout pair comes back in the caller's order.
    assign bx = swap_reg ? y1_reg : x1_reg;
    assign by = swap_reg ? x1_reg : y1_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MS_BS:
            begin
                ma_sel = {{(WW-OPW){rd_data_reg[OPW-1]}}, rd_data_reg};
                mb_sel = y1_reg;
            end
            MS_SX:
            begin
                ma_sel = {{(WW-OPW-1){k33[OPW]}}, k33};
                mb_sel = bx;
            end
            MS_SY:
            begin
                ma_sel = {{(WW-OPW-1){k33[OPW]}}, k33};
                mb_sel = by;
            end
            default:
            begin
                ma_sel = '0;
                mb_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        case (mc_cnt_reg)
            2'd0:
            begin
                pa = ma_reg[OPW-1:0];
                pb = mb_reg[OPW-1:0];
            end
            2'd1:
            begin
                pa = ma_reg[OPW-1:0];
                pb = mb_reg[WW-1:OPW];
            end
            default:
            begin
                pa = ma_reg[WW-1:OPW];
                pb = mb_reg[OPW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mc_busy_reg <= 1'b0;
            mc_done_reg <= 1'b0;
            mc_cnt_reg  <= '0;
        end
        else
        begin
            mc_done_reg <= 1'b0;
            if (cmd.mul_start)
            begin
                mc_busy_reg <= 1'b1;
                mc_cnt_reg  <= '0;
            end
            else if (mc_busy_reg)
            begin
                mc_cnt_reg <= mc_cnt_reg + 1'b1;
                if (mc_cnt_reg == 2'd3)
                begin
                    mc_busy_reg <= 1'b0;
                    mc_done_reg <= 1'b1;
                end
            end
        end
    end

    // The cross terms only reach the upper half of the result.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            ma_reg  <= ma_sel;
            mb_reg  <= mb_sel;
            acc_reg <= '0;
        end
        else if (mc_busy_reg)
        begin
            mp_reg <= pa * pb;
            if (mc_cnt_reg == 2'd1)
            begin
                acc_reg <= acc_reg + mp_reg;
            end
            else if (mc_cnt_reg != 2'd0)
            begin
                acc_reg <= acc_reg + {mp_reg[OPW-1:0], {OPW{1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd.load)
        begin
            n_reg <= '0;
        end
        else if (cmd.push)
        begin
            n_reg <= n_reg + 1'b1;
        end
        else if (cmd.bs_read)
        begin
            n_reg <= n_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[n_reg] <= quo_s;
        end
        if (cmd.bs_read)
        begin
            rd_data_reg <= stack_mem[n_reg - 1'b1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (coef_a > coef_b)
            begin
                p_reg    <= coef_a;
                q_reg    <= coef_b;
                swap_reg <= 1'b0;
            end
            else
            begin
                p_reg    <= coef_b;
                q_reg    <= coef_a;
                swap_reg <= 1'b1;
            end
            c_reg     <= rhs_c;
            x1_reg    <= WW'(1);
            y1_reg    <= WW'(1);
            nosol_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                p_reg <= q_reg;
                q_reg <= rem_s;
            end
            if (cmd.bs_update)
            begin
                x1_reg <= y1_reg;
                y1_reg <= x1_reg - acc_reg;
            end
            if (cmd.set_nosol)
            begin
                nosol_reg <= 1'b1;
            end
        end
        if (cmd.sx_store)
        begin
            solx_reg <= acc_reg;
        end
        if (cmd.sy_store)
        begin
            soly_reg <= acc_reg;
        end
        if (cmd.out_load)
        begin
            ox_reg   <= nosol_reg ? '0 : solx_reg;
            oy_reg   <= nosol_reg ? '0 : soly_reg;
            og_reg   <= p_reg;
            onos_reg <= nosol_reg;
        end
    end

    assign sts.div_done = dv_done_reg;
    assign sts.mul_done = mc_done_reg;
    assign sts.q_zero   = (q_reg == '0);
    assign sts.n_full   = (n_reg == STK_AW'(MAX_STEPS));
    assign sts.n_zero   = (n_reg == '0);
    assign sts.g_zero   = (p_reg == '0);
    assign sts.rem_nz   = (dv_rem_reg != '0);

    assign sol_x       = ox_reg;
    assign sol_y       = oy_reg;
    assign gcd_value   = og_reg;
    assign no_solution = onos_reg;

endmodule

// ===== design/linear_diophantine_solver_unit.sv =====
// Each equation runs a divide per Euclid step, a product per back-substitution step, then
// the last check, the final divide and, when the equation is solvable, the two products.
// One equation is in work at a time; the next may be accepted in the cycle after the
// result loads.
// Reset (rst_n, asynchronous, active low) clears control state only; the quotient
// stack holds no reset value and is only read where the current equation wrote it.
module linear_diophantine_solver_unit
    import lds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [OPW-1:0] coef_a,
    input  logic signed [OPW-1:0] coef_b,
    input  logic signed [OPW-1:0] rhs_c,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [WW-1:0]  sol_x,
    output logic signed [WW-1:0]  sol_y,
    output logic signed [OPW-1:0] gcd_value,
    output logic                  no_solution
);

    lds_cmd_t cmd;
    lds_sts_t sts;

    lds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lds_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .coef_a      (coef_a),
        .coef_b      (coef_b),
        .rhs_c       (rhs_c),
        .sol_x       (sol_x),
        .sol_y       (sol_y),
        .gcd_value   (gcd_value),
        .no_solution (no_solution)
    );

endmodule

// ===== design/lds_checker.sv =====
module lds_checker
    import lds_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic signed [WW-1:0]  sol_x,
    input logic signed [WW-1:0]  sol_y,
    input logic signed [OPW-1:0] gcd_value,
    input logic                  no_solution
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sol_x) && $stable(sol_y)
            && $stable(gcd_value) && $stable(no_solution))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second equation accepted while one is in work");

    a_nosol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_solution |-> sol_x == '0 && sol_y == '0)
        else $error("solution not cleared when flagged unsolvable");

    a_gcd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gcd_value == '0 |-> no_solution)
        else $error("zero gcd without unsolvable flag");

endmodule

bind linear_diophantine_solver_unit lds_checker u_lds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sol_x       (sol_x),
    .sol_y       (sol_y),
    .gcd_value   (gcd_value),
    .no_solution (no_solution)
);
